### design/csmd_pkg.sv
// Shared types, constants and state codes for the capsule segment distance unit.
package csmd_pkg;

  localparam int SEGMENTS = 16;
  localparam int SEG_AW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int CNT_W    = $clog2(SEGMENTS + 1);

  localparam int COORD_W  = 24;
  localparam int THICK_W  = 23;
  localparam int SCNT_W   = 5;
  localparam int DIST_W   = 28;
  localparam int MUL_W    = 27;
  localparam int PROD_W   = 2 * MUL_W;

  // Item opcodes
  localparam logic [1:0] OP_LOAD_START = 2'd0;
  localparam logic [1:0] OP_LOAD_END   = 2'd1;
  localparam logic [1:0] OP_QUERY      = 2'd2;
  localparam logic [1:0] OP_RESERVED   = 2'd3;

  // Register indexes
  localparam logic [1:0] CFG_THICKNESS = 2'd0;
  localparam logic [1:0] CFG_SEG_COUNT = 2'd1;

  localparam logic [THICK_W-1:0] THICK_RESET = 23'd2458;
  localparam logic signed [DIST_W-1:0] DIST_MAX = 28'sd8388607;
  localparam logic signed [DIST_W-1:0] DIST_MIN = -28'sd8388608;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic [3:0]                 slot;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  min_distance;
    logic [3:0]                 nearest_slot;
    logic                       found;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
  } point_t;

  typedef enum logic [2:0] {
    C_IDLE, C_READ, C_START, C_CALC, C_FIN
  } ctl_state_t;

  typedef enum logic [2:0] {
    D_IDLE, D_DOT, D_DEC, D_DIV, D_SCALE, D_SQ, D_SQRT, D_DONE
  } dist_state_t;

endpackage

### design/capsule_segment_min_distance_unit.sv
// Top level: item handshakes, registers, query sequencer and minimum search.
//
//  channel | direction | payload            | accepted when
//  in      | input     | in_item_t          | in_valid & in_ready
//  out     | output    | out_item_t         | out_valid & out_ready
//  cfg     | input     | cfg_index/cfg_data | cfg_valid & cfg_ready
//
// Each searched slot of a query costs a memory read, a start state and a pass
// through the distance unit, whose 16-step divider (skipped when the projection
// is clamped) and 27-step square root dominate. Reset is synchronous and clears
// control state and the configuration registers only; the memories hold garbage
// until loaded. A stalled result waits in the output register while loads
// continue to be taken; a finished query waits until that register is free.
module capsule_segment_min_distance_unit import csmd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [THICK_W-1:0] cfg_data
);

  ctl_state_t state, state_next;
  logic [THICK_W-1:0] thick;
  logic [SCNT_W-1:0]  seg_count;
  logic [CNT_W-1:0]   n, k;
  point_t             pt;
  logic signed [DIST_W-1:0] best;
  logic [CNT_W-1:0]   best_slot;

  logic in_acc, is_load, is_query, out_free;
  logic rd_en, dist_start, dist_done;
  logic [CNT_W-1:0] n_clamp;
  point_t rd_start, rd_end, wr_pt;
  logic signed [DIST_W-1:0] seg_dist, sat;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign is_load   = (in_data.opcode == OP_LOAD_START) || (in_data.opcode == OP_LOAD_END);
  assign is_query  = (in_data.opcode == OP_QUERY);
  assign out_free  = !out_valid || out_ready;
  assign wr_pt     = '{x: in_data.coord_x, y: in_data.coord_y, z: in_data.coord_z};
  assign n_clamp   = (int'(seg_count) > SEGMENTS) ? CNT_W'(SEGMENTS) : CNT_W'(seg_count);

  csmd_store u_store (
    .clk      (clk),
    .wr_en    (in_acc && is_load && (int'(in_data.slot) < SEGMENTS)),
    .wr_end   (in_data.opcode == OP_LOAD_END),
    .wr_addr  (SEG_AW'(in_data.slot)),
    .wr_data  (wr_pt),
    .rd_en    (rd_en),
    .rd_addr  (k[SEG_AW-1:0]),
    .rd_start (rd_start),
    .rd_end   (rd_end)
  );

  csmd_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .start    (dist_start),
    .pt       (pt),
    .seg_s    (rd_start),
    .seg_e    (rd_end),
    .thick    (thick),
    .done     (dist_done),
    .seg_dist (seg_dist)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE: begin
        if (in_acc && is_query) state_next = (n_clamp == '0) ? C_FIN : C_READ;
      end
      C_READ:  state_next = C_START;
      C_START: state_next = C_CALC;
      C_CALC: begin
        if (dist_done) state_next = (k + CNT_W'(1) == n) ? C_FIN : C_READ;
      end
      C_FIN:   if (out_free) state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready   = (state == C_IDLE);
    rd_en      = (state == C_READ);
    dist_start = (state == C_START);
  end

  // Saturate the winning distance
  always_comb begin
    sat = best;
    if (n == '0) sat = DIST_MAX;
    else if (best > DIST_MAX) sat = DIST_MAX;
    else if (best < DIST_MIN) sat = DIST_MIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      out_valid <= 1'b0;
      thick     <= THICK_RESET;
      seg_count <= '0;
    end else begin
      state <= state_next;
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_THICKNESS) thick <= cfg_data;
        if (cfg_index == CFG_SEG_COUNT) seg_count <= cfg_data[SCNT_W-1:0];
      end
      // hold the result until taken
      if (state == C_FIN && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Query payload: point, slot counter and running minimum
  always_ff @(posedge clk) begin
    if (state == C_IDLE && in_acc && is_query) begin
      pt <= wr_pt;
      n  <= n_clamp;
      k  <= '0;
      best_slot <= '0;
    end
    if (state == C_CALC && dist_done) begin
      if (k == '0 || seg_dist < best) begin
        best      <= seg_dist;
        best_slot <= k;
      end
      k <= k + CNT_W'(1);
    end
    if (state == C_FIN && out_free) begin
      out_data.min_distance <= sat[COORD_W-1:0];
      out_data.nearest_slot <= 4'(best_slot);
      out_data.found        <= (n != '0);
    end
  end

endmodule

### design/csmd_store.sv
// Segment endpoint memories: one write port, one registered read port.
module csmd_store import csmd_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              wr_end,
  input  logic [SEG_AW-1:0] wr_addr,
  input  point_t            wr_data,
  input  logic              rd_en,
  input  logic [SEG_AW-1:0] rd_addr,
  output point_t            rd_start,
  output point_t            rd_end
);

  point_t start_mem [SEGMENTS];
  point_t end_mem   [SEGMENTS];

  // Write one endpoint of one slot
  always_ff @(posedge clk) begin
    if (wr_en && !wr_end) begin
      start_mem[wr_addr] <= wr_data;
    end
    if (wr_en && wr_end) begin
      end_mem[wr_addr] <= wr_data;
    end
  end

  // Read both endpoints into registered outputs
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_start <= start_mem[rd_addr];
      rd_end   <= end_mem[rd_addr];
    end
  end

endmodule

### design/csmd_dist.sv
// Multi-cycle point to segment distance unit around one shared multiplier.
module csmd_dist import csmd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  point_t                   pt,
  input  point_t                   seg_s,
  input  point_t                   seg_e,
  input  logic [THICK_W-1:0]       thick,
  output logic                     done,
  output logic signed [DIST_W-1:0] seg_dist
);

  dist_state_t state, state_next;
  logic [4:0] cnt;

  logic signed [24:0] d [3];
  logic signed [24:0] w [3];
  logic signed [26:0] diff [3];
  logic signed [PROD_W-1:0] dot;
  logic [PROD_W-1:0] len2;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] sum;
  logic [PROD_W-1:0] res;
  logic [PROD_W-1:0] sbit;
  logic [16:0] t;
  logic signed [PROD_W-1:0] prod;

  logic signed [MUL_W-1:0] ma, mb;
  logic [2:0] lane3;
  logic [1:0] lane, plane;
  logic [2:0] pk;
  logic signed [MUL_W-1:0] dl, wl, absd;
  logic [PROD_W-1:0] rem_sh, rb;
  logic [24:0] q;
  logic signed [26:0] qs;

  // Pick lanes for the current and the previous multiply
  always_comb begin
    lane3 = (cnt[2:0] >= 3'd3) ? (cnt[2:0] - 3'd3) : cnt[2:0];
    lane  = lane3[1:0];
    pk    = cnt[2:0] - 3'd1;
    plane = (pk >= 3'd3) ? 2'(pk - 3'd3) : pk[1:0];
  end

  // Select multiplier operands
  always_comb begin
    dl   = MUL_W'(d[lane]);
    wl   = MUL_W'(w[lane]);
    absd = dl[MUL_W-1] ? -dl : dl;
    ma   = dl;
    mb   = dl;
    case (state)
      D_DOT: begin
        ma = (cnt[2:0] < 3'd3) ? wl : dl;
        mb = dl;
      end
      D_SCALE: begin
        ma = $signed({10'd0, t});
        mb = absd;
      end
      D_SQ: begin
        ma = MUL_W'(diff[lane]);
        mb = MUL_W'(diff[lane]);
      end
      default: begin
        ma = dl;
        mb = dl;
      end
    endcase
  end

  // Divider and root steps, rounding of the scaled offset
  always_comb begin
    rem_sh = rem << 1;
    rb     = res + sbit;
    q      = 25'((prod + PROD_W'(32768)) >>> 16);
    qs     = d[plane][24] ? -$signed({2'b00, q}) : $signed({2'b00, q});
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE:  if (start) state_next = D_DOT;
      D_DOT:   if (cnt == 5'd6) state_next = D_DEC;
      D_DEC: begin
        if (len2 == '0 || dot <= 0 || $unsigned(dot) >= len2) state_next = D_SCALE;
        else state_next = D_DIV;
      end
      D_DIV:   if (cnt == 5'd15) state_next = D_SCALE;
      D_SCALE: if (cnt == 5'd3) state_next = D_SQ;
      D_SQ:    if (cnt == 5'd3) state_next = D_SQRT;
      D_SQRT:  if (cnt == 5'd26) state_next = D_DONE;
      D_DONE:  state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done     = (state == D_DONE);
    seg_dist = $signed({1'b0, res[26:0]}) - $signed({5'd0, thick});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 5'd0 : cnt + 5'd1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (state)
      D_IDLE: begin
        // latch differences of the segment and the point
        d[0] <= 25'(seg_e.x) - 25'(seg_s.x);
        d[1] <= 25'(seg_e.y) - 25'(seg_s.y);
        d[2] <= 25'(seg_e.z) - 25'(seg_s.z);
        w[0] <= 25'(pt.x) - 25'(seg_s.x);
        w[1] <= 25'(pt.y) - 25'(seg_s.y);
        w[2] <= 25'(pt.z) - 25'(seg_s.z);
        dot  <= '0;
        len2 <= '0;
      end
      D_DOT: begin
        // accumulate the product from the previous cycle
        if (cnt != 5'd0) begin
          if (pk < 3'd3) dot <= dot + prod;
          else len2 <= len2 + $unsigned(prod);
        end
      end
      D_DEC: begin
        sum <= '0;
        rem <= $unsigned(dot);
        if (len2 == '0 || dot <= 0) t <= 17'd0;
        else if ($unsigned(dot) >= len2) t <= 17'd65536;
        else t <= 17'd0;
      end
      D_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem_sh >= len2) begin
          rem <= rem_sh - len2;
          t   <= {t[15:0], 1'b1};
        end else begin
          rem <= rem_sh;
          t   <= {t[15:0], 1'b0};
        end
      end
      D_SCALE: begin
        if (cnt != 5'd0) diff[plane] <= 27'(w[plane]) - qs;
      end
      D_SQ: begin
        if (cnt != 5'd0) sum <= sum + $unsigned(prod);
        res  <= '0;
        sbit <= PROD_W'(1) << 52;
      end
      D_SQRT: begin
        // integer square root, one result bit per cycle
        if (sum >= rb) begin
          sum <= sum - rb;
          res <= (res >> 1) + sbit;
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
      end
      default: begin
      end
    endcase
  end

endmodule
